@@ rtl/mbd_pkg.sv @@
// Shared types and constants for the mipmap box downsampler.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package mbd_pkg;

   localparam int NUM_CH     = 3;   // channel lanes carried through the datapath
   localparam int CHANNELS   = 3;   // lanes at or beyond this index read as zero
   localparam int CFG_W      = 4;   // width of each size exponent register
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SUM_W      = 9;   // horizontal pair sum of two bytes

   typedef logic [7:0] chan_type;
   typedef chan_type [NUM_CH-1:0] pix_type;
   typedef logic [NUM_CH-1:0][SUM_W-1:0] line_type;

   typedef enum logic [0:0] {
      REG_WIDTH_LOG2  = 1'b0,
      REG_HEIGHT_LOG2 = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [3:0] level;
      logic [7:0] pix_x;
      logic [7:0] pix_y;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_READ,
      ST_FLUSH
   } state_type;

endpackage

@@ rtl/mipmap_box_downsampler.sv @@
// Mipmap box downsampler: cascaded 2x2 box filter over a streamed base image.
// Depends on mbd_pkg; holds the level sequencer, line store and result buffer.
`timescale 1ns / 1ps

// Channel | Ports                                  | Direction | Beat
// --------+----------------------------------------+-----------+-------------------------
// req     | req_valid, req_ready, req_data         | in        | one base pixel (RGB)
// rsp     | rsp_valid, rsp_ready, rsp_data         | out       | one mipmap pixel + coords
// csr     | csr_psel/penable/pwrite/paddr/pwdata,  | in/out    | size exponents, 0x0 and 0x4
//         | csr_prdata, csr_pready                 |           |
//
// An item runs through these steps in order when the result side keeps up: the accept,
// a counter step for each level, a line store read and average for each produced pixel,
// and a closing step that releases the final beat.
// The single line store read port and the shared level adder serialise these steps.
// Reset is synchronous and clears the sequencer, counters and exponents; the line store
// and held pixels come up unknown and are only read after a write in the same frame.
// A stalled rsp side holds the sequencer at the next level that has a beat to hand over.
// Oversized images (an exponent beyond MAX_SIZE_LOG2) take beats and drop them.

module mipmap_box_downsampler
   import mbd_pkg::*;
#(
   parameter int MAX_SIZE_LOG2 = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int LINE_DEPTH = (1 << MAX_SIZE_LOG2) - 1;
   localparam int CNT_W      = MAX_SIZE_LOG2;
   localparam int LVL_W      = $clog2(MAX_SIZE_LOG2 + 1);
   localparam int HOLD_IDX_W = (MAX_SIZE_LOG2 > 1) ? $clog2(MAX_SIZE_LOG2) : 1;

   // Configuration
   logic [CFG_W-1:0] width_log2_ff, height_log2_ff;
   logic             csr_wr;
   logic             oversize;

   // Sequencer and per-level position
   state_type        state_ff, state_in;
   logic [LVL_W-1:0] k_ff;
   logic [CNT_W-1:0] col_ff [MAX_SIZE_LOG2+1];
   logic [CNT_W-1:0] row_ff [MAX_SIZE_LOG2+1];

   // Datapath
   pix_type          pix_ff;
   pix_type          pix_req;
   pix_type          avg;
   pix_type          hold_ff [MAX_SIZE_LOG2];
   line_type         line_mem [LINE_DEPTH];
   line_type         rd_ff;
   line_type         pair_sum;
   logic [7:0]       half_x_ff, half_y_ff;

   // Result buffering: pend holds the newest result until its last flag is known
   rsp_type          pend_ff, rsp_ff, new_rsp;
   logic             pend_v_ff, rsp_v_ff;
   logic             out_free;

   // Level step decode
   logic [CFG_W-1:0] k4, sh_w, sh_h;
   logic [CNT_W-1:0] cur_x, cur_y;
   logic             col_last, row_last, stop_level;
   logic [CNT_W-1:0] line_idx;

   // Control strobes
   logic             accept, step_go, read_go, flush_go;
   logic             hold_we, line_we, line_re;

   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign oversize = (width_log2_ff > CFG_W'(MAX_SIZE_LOG2))
                  || (height_log2_ff > CFG_W'(MAX_SIZE_LOG2));
   assign out_free = !rsp_v_ff || rsp_ready;

   assign k4       = CFG_W'(k_ff);
   assign cur_x    = col_ff[k_ff];
   assign cur_y    = row_ff[k_ff];
   assign sh_w     = width_log2_ff - k4;
   assign sh_h     = height_log2_ff - k4;
   assign col_last = (cur_x == CNT_W'((1 << sh_w) - 1));
   assign row_last = (cur_y == CNT_W'((1 << sh_h) - 1));
   // next level would have a zero dimension
   assign stop_level = (k4 >= width_log2_ff) || (k4 >= height_log2_ff)
                    || (k4 >= CFG_W'(MAX_SIZE_LOG2));
   // each level owns a segment of the line store, halving in size per level
   assign line_idx = CNT_W'((1 << MAX_SIZE_LOG2) - (1 << (MAX_SIZE_LOG2 - int'(k_ff))))
                   + CNT_W'(cur_x >> 1);

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         pair_sum[c] = SUM_W'(hold_ff[k_ff[HOLD_IDX_W-1:0]][c]) + SUM_W'(pix_ff[c]);
         avg[c]      = 8'((10'(rd_ff[c]) + 10'(hold_ff[k_ff[HOLD_IDX_W-1:0]][c])
                          + 10'(pix_ff[c])) >> 2);
      end
   end

   assign pix_req[0] = (0 < CHANNELS) ? req_data.red   : '0;
   assign pix_req[1] = (1 < CHANNELS) ? req_data.green : '0;
   assign pix_req[2] = (2 < CHANNELS) ? req_data.blue  : '0;

   always_comb begin
      new_rsp           = '0;
      new_rsp.level     = 4'(k_ff + LVL_W'(1));
      new_rsp.pix_x     = half_x_ff;
      new_rsp.pix_y     = half_y_ff;
      new_rsp.out_red   = avg[0];
      new_rsp.out_green = avg[1];
      new_rsp.out_blue  = avg[2];
      new_rsp.last      = 1'b0;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !oversize) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (stop_level || !cur_x[0] || !cur_y[0]) state_in = ST_FLUSH;
            else                                      state_in = ST_READ;
         end
         ST_READ: begin
            if (!pend_v_ff || out_free) state_in = ST_STEP;
         end
         ST_FLUSH: begin
            if (!pend_v_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and strobes
   always_comb begin
      req_ready = 1'b0;
      accept    = 1'b0;
      step_go   = 1'b0;
      read_go   = 1'b0;
      flush_go  = 1'b0;
      hold_we   = 1'b0;
      line_we   = 1'b0;
      line_re   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid && !oversize;
         end
         ST_STEP: begin
            step_go = 1'b1;
            if (!stop_level) begin
               hold_we = !cur_x[0];
               line_we = cur_x[0] && !cur_y[0];
               line_re = cur_x[0] && cur_y[0];
            end
         end
         ST_READ:  read_go  = !pend_v_ff || out_free;
         ST_FLUSH: flush_go = pend_v_ff && out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         width_log2_ff  <= '0;
         height_log2_ff <= '0;
         k_ff           <= '0;
         pend_v_ff      <= 1'b0;
         rsp_v_ff       <= 1'b0;
         for (int i = 0; i <= MAX_SIZE_LOG2; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (accept) k_ff <= '0;

         // a frame restarts on any size write
         if (csr_wr) begin
            unique case (reg_idx_type'(csr_paddr[2]))
               REG_WIDTH_LOG2:  width_log2_ff  <= csr_pwdata[CFG_W-1:0];
               REG_HEIGHT_LOG2: height_log2_ff <= csr_pwdata[CFG_W-1:0];
               default: ;
            endcase
            for (int i = 0; i <= MAX_SIZE_LOG2; i++) begin
               col_ff[i] <= '0;
               row_ff[i] <= '0;
            end
         end else if (step_go) begin
            // advance this level's raster position
            if (col_last) begin
               col_ff[k_ff] <= '0;
               row_ff[k_ff] <= row_last ? '0 : cur_y + CNT_W'(1);
            end else begin
               col_ff[k_ff] <= cur_x + CNT_W'(1);
            end
         end

         if (read_go) begin
            // keep the new result until its successor shows
            pend_v_ff <= 1'b1;
            k_ff      <= k_ff + LVL_W'(1);
         end

         if (flush_go) pend_v_ff <= 1'b0;

         // load the older result into the output register, else release it once taken
         if ((read_go && pend_v_ff) || flush_go) rsp_v_ff <= 1'b1;
         else if (rsp_v_ff && rsp_ready)         rsp_v_ff <= 1'b0;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) pix_ff <= pix_req;
      if (step_go) begin
         half_x_ff <= 8'(cur_x >> 1);
         half_y_ff <= 8'(cur_y >> 1);
      end
      if (hold_we) hold_ff[k_ff[HOLD_IDX_W-1:0]] <= pix_ff;
      if (read_go) begin
         pix_ff  <= avg;
         pend_ff <= new_rsp;
         if (pend_v_ff) rsp_ff <= pend_ff;
      end
      // mark the closing beat as last
      if (flush_go) rsp_ff <= {pend_ff[$bits(rsp_type)-1:1], 1'b1};
   end

   // Line store: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (line_we) line_mem[line_idx] <= pair_sum;
      if (line_re) rd_ff <= line_mem[line_idx];
   end

   assign rsp_valid  = rsp_v_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      unique case (reg_idx_type'(csr_paddr[2]))
         REG_WIDTH_LOG2:  csr_prdata = CSR_DATA_W'(width_log2_ff);
         REG_HEIGHT_LOG2: csr_prdata = CSR_DATA_W'(height_log2_ff);
         default: ;
      endcase
   end

endmodule

@@ rtl/mbd_checker.sv @@
// Port-level checks for the mipmap box downsampler, with its bind.
// Depends on mbd_pkg and the top level mipmap_box_downsampler.
`timescale 1ns / 1ps

module mbd_checker
   import mbd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // produced pixels never belong to the base level
   a_level_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.level != 4'd0)
      else $error("rsp beat with level zero");

   // a written width exponent reads back, zero-extended
   a_width_readback: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_paddr[2] == 1'b0 |=>
         csr_paddr[2] != 1'b0
         || csr_prdata == CSR_DATA_W'($past(csr_pwdata[CFG_W-1:0])))
      else $error("width exponent read back wrong");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("csr_pready dropped");

endmodule

bind mipmap_box_downsampler mbd_checker u_mbd_checker (.*);
